// ===== hdl/tpr_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tpr_pkg
// Shared types and constants of the Targa pixel RLE decoder.
// ----------------------------------------------------------------------------
package tpr_pkg;

  localparam int unsigned MaxSide   = 32767;
  localparam int unsigned SideW     = 15;
  localparam int unsigned TotalW    = 2 * SideW;
  localparam int unsigned CfgDataW  = SideW;
  localparam int unsigned CfgIndexW = 2;

  localparam logic [7:0] LenMask   = 8'h7F;
  localparam logic [7:0] RunFlag   = 8'h80;
  localparam logic [7:0] AlphaFull = 8'hFF;

  typedef enum logic [CfgIndexW-1:0] {
    REG_PIXEL_FORMAT = 2'd0,
    REG_COMPRESSED   = 2'd1,
    REG_IMAGE_WIDTH  = 2'd2,
    REG_IMAGE_HEIGHT = 2'd3
  } tpr_reg_e;

  typedef enum logic [1:0] {
    FMT_GRAY8  = 2'd0,
    FMT_BGR24  = 2'd1,
    FMT_BGRA32 = 2'd2,
    FMT_ALT32  = 2'd3
  } tpr_fmt_e;

  typedef struct packed {
    logic [7:0] data_byte;
    logic       image_start;
  } tpr_in_t;

  typedef struct packed {
    logic [7:0] red;
    logic [7:0] green;
    logic [7:0] blue;
    logic [7:0] alpha;
    logic [7:0] repeat_res;
    logic       image_done;
    logic       run_clipped;
  } tpr_out_t;

  // Settings seen by the decode datapath
  typedef struct packed {
    logic [1:0]        pixel_format;
    logic              compressed;
    logic [TotalW-1:0] total;
  } tpr_cfg_t;

endpackage

// ===== hdl/tpr_cfg_regs.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tpr_cfg_regs
// Configuration registers and the registered pixel count of the image.
// ----------------------------------------------------------------------------
module tpr_cfg_regs
  import tpr_pkg::*;
(
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 cfg_we_i,
  input  logic [CfgIndexW-1:0] cfg_index_i,
  input  logic [CfgDataW-1:0]  cfg_data_i,
  output tpr_cfg_t             cfg_o
);

  logic [1:0]       fmt_q;
  logic             comp_q;
  logic [SideW-1:0] width_q;
  logic [SideW-1:0] height_q;
  logic [SideW-1:0] width_c;
  logic [SideW-1:0] height_c;
  logic [TotalW-1:0] total_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      fmt_q    <= FMT_BGRA32;
      comp_q   <= 1'b1;
      width_q  <= SideW'(1);
      height_q <= SideW'(1);
    end else if (cfg_we_i) begin
      case (tpr_reg_e'(cfg_index_i))
        REG_PIXEL_FORMAT: fmt_q    <= cfg_data_i[1:0];
        REG_COMPRESSED:   comp_q   <= cfg_data_i[0];
        REG_IMAGE_WIDTH:  width_q  <= cfg_data_i[SideW-1:0];
        REG_IMAGE_HEIGHT: height_q <= cfg_data_i[SideW-1:0];
        default: ;
      endcase
    end
  end

  // Zero counts as one side, oversized counts as the maximum side
  always_comb begin
    width_c = width_q;
    if (width_q == '0) width_c = SideW'(1);
    else if (width_q > SideW'(MaxSide)) width_c = SideW'(MaxSide);
    height_c = height_q;
    if (height_q == '0) height_c = SideW'(1);
    else if (height_q > SideW'(MaxSide)) height_c = SideW'(MaxSide);
  end

  // Product is registered behind the side registers; writes must come only while idle (the block does not enforce this)
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      total_q <= TotalW'(1);
    end else begin
      total_q <= TotalW'(width_c) * TotalW'(height_c);
    end
  end

  assign cfg_o.pixel_format = fmt_q;
  assign cfg_o.compressed   = comp_q;
  assign cfg_o.total        = total_q;

endmodule

// ===== hdl/tga_pixel_rle_decoder.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tga_pixel_rle_decoder
// Decodes Targa pixel-data bytes (raw or RLE) into RGBA results with repeat.
// ----------------------------------------------------------------------------
// Usage:
//   Bytes enter on the in channel (in_valid_i / in_stall_o), one transaction
//   per byte; image_start marks the first byte of an image and clears the
//   decode state before that byte. Decoded pixels leave on the out channel
//   (out_valid_o / out_stall_i), one transaction per pixel or per run.
//   Packet headers and partial pixel bytes give no output transaction.
//   A taken byte waits in the input register and is decoded from there;
//   its result is written to the output register as the byte is processed.
//   Throughput: one byte per cycle while the receiver does not stall,
//   set by the single input register feeding the decode stage and output
//   register. When the receiver stalls, the held result stays put, the byte
//   in the input register waits, and in_stall_o rises once that register is
//   full. Configuration writes land in their registers; the pixel total of
//   the image is registered from them in the cycle after. Reset restores the
//   default settings, clears all decode state and empties both registers.
// ----------------------------------------------------------------------------
module tga_pixel_rle_decoder
  import tpr_pkg::*;
(
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 cfg_we_i,
  input  logic [CfgIndexW-1:0] cfg_index_i,
  input  logic [CfgDataW-1:0]  cfg_data_i,
  input  logic                 in_valid_i,
  output logic                 in_stall_o,
  input  tpr_in_t              in_data_i,
  output logic                 out_valid_o,
  input  logic                 out_stall_i,
  output tpr_out_t             out_data_o
);

  tpr_cfg_t cfg;

  tpr_cfg_regs u_cfg (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we_i),
    .cfg_index_i (cfg_index_i),
    .cfg_data_i  (cfg_data_i),
    .cfg_o       (cfg)
  );

  // Input register
  logic    in_valid_q;
  tpr_in_t in_q;
  logic    proc;
  logic    in_take;

  // Decode state
  logic [23:0]       buf_q, buf_e, buf_d;
  logic [1:0]        pos_q, pos_e, pos_d;
  logic              inpk_q, inpk_e, inpk_d;
  logic              run_q, run_e, run_d;
  logic [7:0]        rem_q, rem_e, rem_d;
  logic [TotalW-1:0] pw_q, pw_e, pw_d;
  logic              fin_q, fin_e, fin_d;

  // Output register
  logic     out_valid_q;
  tpr_out_t out_q;
  logic     has_res;
  tpr_out_t res;

  logic [2:0]      need;
  logic [7:0]      b;
  logic [7:0]      by0, by1, by2, by3;
  logic [7:0]      rpt;
  logic [TotalW:0] left_w;

  assign proc       = in_valid_q && (!out_valid_q || !out_stall_i);
  assign in_stall_o = in_valid_q && !proc;
  assign in_take    = in_valid_i && !in_stall_o;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q <= 1'b0;
    end else if (in_take) begin
      in_valid_q <= 1'b1;
    end else if (proc) begin
      in_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_take) in_q <= in_data_i;
  end

  // Start of image clears the state before the byte is handled
  always_comb begin
    b      = in_q.data_byte;
    buf_e  = in_q.image_start ? '0   : buf_q;
    pos_e  = in_q.image_start ? '0   : pos_q;
    inpk_e = in_q.image_start ? 1'b0 : inpk_q;
    run_e  = in_q.image_start ? 1'b0 : run_q;
    rem_e  = in_q.image_start ? '0   : rem_q;
    pw_e   = in_q.image_start ? '0   : pw_q;
    fin_e  = in_q.image_start ? 1'b0 : fin_q;
  end

  always_comb begin
    case (tpr_fmt_e'(cfg.pixel_format))
      FMT_GRAY8: need = 3'd1;
      FMT_BGR24: need = 3'd3;
      default:   need = 3'd4;
    endcase
  end

  // Bytes not gathered read as zero
  always_comb begin
    by0 = (pos_e == 2'd0) ? b : buf_e[7:0];
    by1 = (pos_e == 2'd1) ? b : ((pos_e > 2'd1) ? buf_e[15:8] : 8'h00);
    by2 = (pos_e == 2'd2) ? b : ((pos_e > 2'd2) ? buf_e[23:16] : 8'h00);
    by3 = (pos_e == 2'd3) ? b : 8'h00;
  end

  // Borrow in the top bit means more pixels written than the image holds
  assign left_w = {1'b0, cfg.total} - {1'b0, pw_e};

  always_comb begin
    buf_d   = buf_e;
    pos_d   = pos_e;
    inpk_d  = inpk_e;
    run_d   = run_e;
    rem_d   = rem_e;
    pw_d    = pw_e;
    fin_d   = fin_e;
    has_res = 1'b0;
    rpt     = 8'd1;
    res     = '0;
    if (!fin_e) begin
      if (cfg.compressed && !inpk_e) begin
        // Packet header
        run_d  = (b & RunFlag) != 8'h00;
        rem_d  = (b & LenMask) + 8'd1;
        inpk_d = 1'b1;
      end else if ({1'b0, pos_e} + 3'd1 < need) begin
        case (pos_e)
          2'd0:    buf_d = {buf_e[23:8], b};
          2'd1:    buf_d = {buf_e[23:16], b, buf_e[7:0]};
          default: buf_d = {b, buf_e[15:0]};
        endcase
        pos_d = pos_e + 2'd1;
      end else begin
        has_res = 1'b1;
        buf_d   = '0;
        pos_d   = '0;
        if (need == 3'd1) begin
          res.red   = by0;
          res.green = by0;
          res.blue  = by0;
          res.alpha = AlphaFull;
        end else begin
          res.blue  = by0;
          res.green = by1;
          res.red   = by2;
          res.alpha = (need == 3'd4) ? by3 : AlphaFull;
        end
        if (cfg.compressed && run_e) begin
          rpt = (rem_e == 8'd0) ? 8'd1 : rem_e;
          if (!left_w[TotalW] && (TotalW'(rpt) > left_w[TotalW-1:0])) begin
            rpt             = left_w[7:0];
            res.run_clipped = 1'b1;
          end
          rem_d  = '0;
          inpk_d = 1'b0;
        end else if (cfg.compressed) begin
          rem_d = rem_e - 8'd1;
          if (rem_d == 8'd0) inpk_d = 1'b0;
        end
        pw_d           = pw_e + TotalW'(rpt);
        fin_d          = pw_d >= cfg.total;
        res.repeat_res = rpt;
        res.image_done = fin_d;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      buf_q  <= '0;
      pos_q  <= '0;
      inpk_q <= 1'b0;
      run_q  <= 1'b0;
      rem_q  <= '0;
      pw_q   <= '0;
      fin_q  <= 1'b0;
    end else if (proc) begin
      buf_q  <= buf_d;
      pos_q  <= pos_d;
      inpk_q <= inpk_d;
      run_q  <= run_d;
      rem_q  <= rem_d;
      pw_q   <= pw_d;
      fin_q  <= fin_d;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (proc) begin
      out_valid_q <= has_res;
    end else if (!out_stall_i) begin
      out_valid_q <= 1'b0;
    end
  end

  // Hold the payload while stalled
  always_ff @(posedge clk_i) begin
    if (proc && has_res) out_q <= res;
  end

  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_q;

endmodule
